FILE: rtl/core/whs_pkg.sv
// ----------------------------------------------------------------------------
// whs_pkg: shared types and constants of the weighted hash server select
// Transaction payloads, configuration register decode, state codes and the
// default sizing of the server table.
// ----------------------------------------------------------------------------
package whs_pkg;

   // Default sizing
   localparam int MAX_SERVERS_DEF = 8;
   localparam int WEIGHT_BITS_DEF = 8;

   // Fixed field widths
   localparam int HASH_W     = 32;
   localparam int HASH_CNT_W = $clog2(HASH_W);
   localparam int SRV_W      = 3;
   localparam int MASK_W     = 3;
   localparam int COUNT_W    = 4;
   localparam int WEIGHTS_W  = 64;

   // Configuration port: 64-bit registers on an 8-byte stride
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;
   localparam logic CSR_IDX_COUNT   = 1'b0;
   localparam logic CSR_IDX_WEIGHTS = 1'b1;

   localparam logic [COUNT_W-1:0]   COUNT_RESET   = 4'd1;
   localparam logic [WEIGHTS_W-1:0] WEIGHTS_RESET = 64'h0101_0101_0101_0101;

   // Operation codes
   localparam logic OP_SELECT = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   typedef struct packed {
      logic              op;
      logic [HASH_W-1:0] hash;
      logic [SRV_W-1:0]  server;
      logic [MASK_W-1:0] busy_mask;
   } whs_req_type;

   typedef struct packed {
      logic [SRV_W-1:0] server_index;
      logic             used_fallback;
      logic             weight_error;
   } whs_rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SUM,
      S_DIV,
      S_SCAN,
      S_DONE
   } whs_state_type;

endpackage

FILE: rtl/core/weighted_hash_server_select.sv
// An update sets the busy bit of its server and goes straight to the result; a select sums
// the weights and ends there with one server in use or zero total weight; else it takes the
// hash modulo the sum, scans to the hit and repeats over the idle set if that one is busy.
// One transaction at a time: a request is stalled until the last result is in the output
// register; the bit-serial remainder (one hash bit a cycle), the scans and output stalls set the rate.
// Reset (synchronous): no server busy, one server in use, every weight one, output empty.
// ----------------------------------------------------------------------------
// weighted_hash_server_select
// Weighted hash load balancer: sums the server weights one server a cycle,
// takes the hash modulo the sum one bit a cycle, walks the cumulative weights
// to the owning server, and repeats over the idle servers when it is busy.
// ----------------------------------------------------------------------------
module weighted_hash_server_select #(
   parameter int MAX_SERVERS = whs_pkg::MAX_SERVERS_DEF,
   parameter int WEIGHT_BITS = whs_pkg::WEIGHT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  whs_pkg::whs_req_type                req_data,
   // Response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output whs_pkg::whs_rsp_type                rsp_data,
   // Configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [whs_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [whs_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [whs_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);
   import whs_pkg::*;

   localparam int IDX_W = $clog2(MAX_SERVERS);
   localparam int SUM_W = $clog2(MAX_SERVERS * ((1 << WEIGHT_BITS) - 1) + 1);

   whs_state_type          state_ff, state_in;
   logic [HASH_W-1:0]      hash_ff, hash_in;
   logic [HASH_W-1:0]      dsh_ff, dsh_in;
   logic [HASH_CNT_W-1:0]  bit_ff, bit_in;
   logic [SUM_W-1:0]       rem_ff, rem_in;
   logic [SUM_W-1:0]       div_ff, div_in;
   logic [WEIGHTS_W-1:0]   wsh_ff, wsh_in;
   logic [IDX_W-1:0]       cnt_ff, cnt_in;
   logic [IDX_W-1:0]       last_ff, last_in;
   logic [SUM_W-1:0]       total_ff, total_in;
   logic [SUM_W-1:0]       idle_ff, idle_in;
   logic [SUM_W-1:0]       cum_ff, cum_in;
   logic                   second_ff, second_in;
   whs_rsp_type            res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   whs_rsp_type            rsp_data_ff, rsp_data_in;
   logic [MAX_SERVERS-1:0] busy_ff, busy_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [WEIGHTS_W-1:0]   weights_ff, weights_in;

   logic [SUM_W-1:0]       w_ext;
   logic                   cur_busy;
   logic [SUM_W-1:0]       sum_total;
   logic [SUM_W-1:0]       sum_idle;
   logic [SUM_W:0]         trial;
   logic [SUM_W-1:0]       rem_next;
   logic                   skip;
   logic [SUM_W-1:0]       cum_next;
   logic                   hit;
   logic [IDX_W-1:0]       act_last;
   logic                   csr_wr;

   // Per-server step: weight at the bottom of the shift line, busy bit of the counter
   assign w_ext     = SUM_W'(wsh_ff[WEIGHT_BITS-1:0]);
   assign cur_busy  = busy_ff[cnt_ff];
   assign sum_total = total_ff + w_ext;
   assign sum_idle  = cur_busy ? idle_ff : idle_ff + w_ext;

   // Restoring remainder step: one hash bit a cycle
   assign trial    = {rem_ff, dsh_ff[HASH_W-1]};
   assign rem_next = (trial >= {1'b0, div_ff}) ? SUM_W'(trial - {1'b0, div_ff})
                                               : SUM_W'(trial);

   // Cumulative scan step: busy servers drop out of the fallback pass
   assign skip     = second_ff && cur_busy;
   assign cum_next = skip ? cum_ff : cum_ff + w_ext;
   assign hit      = !skip && (rem_ff < cum_next);

   // Last server in use: count zero means one, saturate at the table depth
   always_comb begin
      if (count_ff == '0) begin
         act_last = '0;
      end else if (32'(count_ff) > MAX_SERVERS) begin
         act_last = IDX_W'(MAX_SERVERS - 1);
      end else begin
         act_last = IDX_W'(count_ff - 4'd1);
      end
   end

   assign csr_wr    = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Register read
   always_comb begin
      unique case (paddr[3])
         CSR_IDX_COUNT:   prdata = CSR_DATA_W'(count_ff);
         CSR_IDX_WEIGHTS: prdata = weights_ff;
         default:         prdata = '0;
      endcase
   end

   // Next state and datapath
   always_comb begin
      state_in     = state_ff;
      hash_in      = hash_ff;
      dsh_in       = dsh_ff;
      bit_in       = bit_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      wsh_in       = wsh_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      total_in     = total_ff;
      idle_in      = idle_ff;
      cum_in       = cum_ff;
      second_in    = second_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      busy_in      = busy_ff;
      count_in     = count_ff;
      weights_in   = weights_ff;

      // Drop a taken response
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Configuration writes
      if (csr_wr) begin
         if (paddr[3] == CSR_IDX_COUNT) begin
            count_in = pwdata[COUNT_W-1:0];
         end else begin
            weights_in = pwdata;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_in = '0;
               if (req_data.op == OP_UPDATE) begin
                  if (32'(req_data.server) < MAX_SERVERS) begin
                     busy_in[IDX_W'(req_data.server)] = |req_data.busy_mask;
                  end
                  state_in = S_DONE;
               end else begin
                  hash_in   = req_data.hash;
                  last_in   = act_last;
                  wsh_in    = weights_ff;
                  cnt_in    = '0;
                  total_in  = '0;
                  idle_in   = '0;
                  second_in = 1'b0;
                  state_in  = S_SUM;
               end
            end
         end

         S_SUM: begin
            // Accumulate total and idle weight, one server a cycle
            total_in = sum_total;
            idle_in  = sum_idle;
            wsh_in   = wsh_ff >> WEIGHT_BITS;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == last_ff) begin
               if (sum_total == '0) begin
                  res_in.weight_error = 1'b1;
                  state_in = S_DONE;
               end else if (last_ff == '0) begin
                  state_in = S_DONE;
               end else begin
                  div_in   = sum_total;
                  rem_in   = '0;
                  dsh_in   = hash_ff;
                  bit_in   = '0;
                  state_in = S_DIV;
               end
            end
         end

         S_DIV: begin
            rem_in = rem_next;
            dsh_in = dsh_ff << 1;
            bit_in = bit_ff + 1'b1;
            if (bit_ff == HASH_CNT_W'(HASH_W - 1)) begin
               wsh_in   = weights_ff;
               cnt_in   = '0;
               cum_in   = '0;
               state_in = S_SCAN;
            end
         end

         S_SCAN: begin
            cum_in = cum_next;
            wsh_in = wsh_ff >> WEIGHT_BITS;
            cnt_in = cnt_ff + 1'b1;
            if (hit) begin
               if (!second_ff && cur_busy && (idle_ff != '0)) begin
                  // Primary choice busy: redo over the idle servers
                  second_in = 1'b1;
                  div_in    = idle_ff;
                  rem_in    = '0;
                  dsh_in    = hash_ff;
                  bit_in    = '0;
                  state_in  = S_DIV;
               end else begin
                  res_in.server_index  = SRV_W'(cnt_ff);
                  res_in.used_fallback = second_ff;
                  state_in = S_DONE;
               end
            end else if (cnt_ff == last_ff) begin
               res_in.server_index  = '0;
               res_in.used_fallback = second_ff;
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            // Hand the result to the output register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         busy_ff      <= '0;
         count_ff     <= COUNT_RESET;
         weights_ff   <= WEIGHTS_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         weights_ff   <= weights_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      hash_ff     <= hash_in;
      dsh_ff      <= dsh_in;
      bit_ff      <= bit_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      wsh_ff      <= wsh_in;
      cnt_ff      <= cnt_in;
      last_ff     <= last_in;
      total_ff    <= total_in;
      idle_ff     <= idle_in;
      cum_ff      <= cum_in;
      second_ff   <= second_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < div_ff))
      else $error("remainder not below divisor");

   a_fallback_divisor: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DIV || state_ff == S_SCAN) && second_ff) |->
         (div_ff == idle_ff && idle_ff != '0))
      else $error("fallback pass not over idle weight");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM || state_ff == S_SCAN) |-> (cnt_ff <= last_ff))
      else $error("server counter beyond servers in use");

   a_error_result_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.weight_error) |->
         (rsp_data_ff.server_index == '0 && !rsp_data_ff.used_fallback))
      else $error("weight error with nonzero choice");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("accepted transaction not started");
`endif

endmodule
